FILE: design/parst_pkg.sv
// Package for the point-add / range-sum segment tree.
// Holds the microcode word types, the step addresses and the control store.
// No dependencies.
package parst_pkg;

  localparam int unsigned DEF_LEAVES = 1024;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned RIGHT_W = 11;

  // Microcode step addresses
  typedef enum logic [3:0] {
    U_CLR,
    U_IDLE,
    U_DISP,
    A_LOAD,
    A_RD,
    A_WR,
    A_TOP,
    A_PAR,
    Q_LOAD,
    Q_LO,
    Q_HI,
    Q_SH,
    Q_OUT
  } upc_e;

  // Branch conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_K_LAST,
    C_NO_REQ,
    C_QUERY,
    C_POS_OOR,
    C_K_ROOT,
    C_EMPTY,
    C_LO_EVEN,
    C_HI_EVEN,
    C_WALK_DONE,
    C_OUT_BUSY
  } cond_e;

  typedef enum logic [1:0] {
    M_NONE,
    M_RD,
    M_WR
  } mem_e;

  typedef enum logic [2:0] {
    AD_K,
    AD_SIB,
    AD_PAR,
    AD_LO,
    AD_HI_M1
  } addr_e;

  typedef enum logic [1:0] {
    WD_ZERO,
    WD_LEAF,
    WD_PAIR
  } wd_e;

  typedef enum logic [1:0] {
    AC_HOLD,
    AC_CLEAR,
    AC_LEAF,
    AC_PAIR
  } acc_e;

  typedef enum logic [1:0] {
    KO_HOLD,
    KO_INC,
    KO_LEAF,
    KO_HALF
  } kop_e;

  typedef enum logic [2:0] {
    BO_HOLD,
    BO_LOAD,
    BO_LO_INC,
    BO_HI_DEC,
    BO_SHIFT
  } bnd_e;

  // One control word. When gate is set and the condition holds, the
  // step's actions are dropped and only the branch is taken.
  typedef struct packed {
    mem_e  mem;
    addr_e addr;
    wd_e   wd;
    acc_e  acc;
    kop_e  kop;
    bnd_e  bnd;
    logic  pend;
    logic  out_load;
    logic  gate;
    cond_e cond;
    upc_e  tgt_t;
    upc_e  tgt_f;
  } uword_t;

  localparam uword_t UW_NOP = '{
    mem: M_NONE, addr: AD_K, wd: WD_ZERO, acc: AC_HOLD, kop: KO_HOLD,
    bnd: BO_HOLD, pend: 1'b0, out_load: 1'b0, gate: 1'b0, cond: C_NEVER,
    tgt_t: U_IDLE, tgt_f: U_IDLE
  };

  // Control store
  function automatic uword_t ucode(input upc_e a);
    uword_t w;
    w = UW_NOP;
    case (a)
      U_CLR: begin
        w.mem = M_WR; w.addr = AD_K; w.wd = WD_ZERO; w.kop = KO_INC;
        w.cond = C_K_LAST; w.tgt_t = U_IDLE; w.tgt_f = U_CLR;
      end
      U_IDLE: begin
        w.cond = C_NO_REQ; w.tgt_t = U_IDLE; w.tgt_f = U_DISP;
      end
      U_DISP: begin
        w.cond = C_QUERY; w.tgt_t = Q_LOAD; w.tgt_f = A_LOAD;
      end
      A_LOAD: begin
        w.kop = KO_LEAF; w.gate = 1'b1;
        w.cond = C_POS_OOR; w.tgt_t = U_IDLE; w.tgt_f = A_RD;
      end
      A_RD: begin
        w.mem = M_RD; w.addr = AD_K; w.tgt_f = A_WR;
      end
      A_WR: begin
        w.mem = M_WR; w.addr = AD_K; w.wd = WD_LEAF; w.acc = AC_LEAF;
        w.tgt_f = A_TOP;
      end
      A_TOP: begin
        w.mem = M_RD; w.addr = AD_SIB; w.gate = 1'b1;
        w.cond = C_K_ROOT; w.tgt_t = U_IDLE; w.tgt_f = A_PAR;
      end
      A_PAR: begin
        w.mem = M_WR; w.addr = AD_PAR; w.wd = WD_PAIR; w.acc = AC_PAIR;
        w.kop = KO_HALF; w.tgt_f = A_TOP;
      end
      Q_LOAD: begin
        w.acc = AC_CLEAR; w.bnd = BO_LOAD;
        w.cond = C_EMPTY; w.tgt_t = Q_OUT; w.tgt_f = Q_LO;
      end
      Q_LO: begin
        w.mem = M_RD; w.addr = AD_LO; w.bnd = BO_LO_INC; w.pend = 1'b1;
        w.gate = 1'b1; w.cond = C_LO_EVEN; w.tgt_t = Q_HI; w.tgt_f = Q_HI;
      end
      Q_HI: begin
        w.mem = M_RD; w.addr = AD_HI_M1; w.bnd = BO_HI_DEC; w.pend = 1'b1;
        w.gate = 1'b1; w.cond = C_HI_EVEN; w.tgt_t = Q_SH; w.tgt_f = Q_SH;
      end
      Q_SH: begin
        w.bnd = BO_SHIFT;
        w.cond = C_WALK_DONE; w.tgt_t = Q_OUT; w.tgt_f = Q_LO;
      end
      Q_OUT: begin
        w.out_load = 1'b1; w.gate = 1'b1;
        w.cond = C_OUT_BUSY; w.tgt_t = Q_OUT; w.tgt_f = U_IDLE;
      end
      default: begin
        w = UW_NOP;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: design/point_add_range_sum_tree.sv
// Top level of the point-add / range-sum segment tree: microcode sequencer,
// datapath and single-port node memory. Depends on parst_pkg.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------------
//  in      | input     | in_valid_i / in_ready_o | command_i position_i right_end_i delta_i
//  out     | output    | out_valid_o/out_ready_i | range_sum_o
//
// Requests: one at a time. An add walks from its leaf up to the root and a
// query walks the tree level by level, both paced by the single-port node
// memory, which serves one read or one write per microcode step.
// Reset: a clearing pass writes zero to all 2*LEAVES nodes, one per cycle,
// before the first request is taken. Stalls: a finished sum waits in the
// output register while the next request is accepted and worked on.
module point_add_range_sum_tree
  import parst_pkg::*;
#(
  parameter int unsigned LEAVES = DEF_LEAVES
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      command_i,
  input  logic [POS_W-1:0]          position_i,
  input  logic [RIGHT_W-1:0]        right_end_i,
  input  logic signed [DATA_W-1:0]  delta_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [DATA_W-1:0]  range_sum_o
);

  // Node index width, bound width (bounds reach 2*LEAVES), compare width
  localparam int unsigned NODES  = 2 * LEAVES;
  localparam int unsigned NODE_W = $clog2(NODES);
  localparam int unsigned HW     = NODE_W + 1;
  localparam int unsigned EW     = ((HW > RIGHT_W) ? HW : RIGHT_W) + 1;

  localparam logic [EW-1:0]     L_E    = EW'(LEAVES);
  localparam logic [HW-1:0]     L_H    = HW'(LEAVES);
  localparam logic [NODE_W-1:0] L_N    = NODE_W'(LEAVES);
  localparam logic [NODE_W-1:0] K_LAST = NODE_W'(NODES - 1);

  // Sequencer
  upc_e   upc_q, upc_d;
  uword_t uw;
  logic   hit, en;

  // Request latch
  logic              cmd_q;
  logic [POS_W-1:0]  pos_q;
  logic [RIGHT_W-1:0] rend_q;
  logic [DATA_W-1:0] delta_q;

  // Datapath
  logic [NODE_W-1:0] k_q, k_d;
  logic [HW-1:0]     lo_q, lo_d, hi_q, hi_d;
  logic [DATA_W-1:0] acc_q, acc_d;
  logic              pend_q, pend_d;
  logic [DATA_W-1:0] rd_q;
  logic [DATA_W-1:0] sum_leaf, sum_pair, wdata;
  logic [NODE_W-1:0] addr;
  logic              mem_we, mem_re;

  logic [EW-1:0]     pos_e, rend_e, hs_e;
  logic [HW-1:0]     hi_m1;

  // Output register
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] sum_q;
  logic              out_load;

  logic [DATA_W-1:0] mem_q [NODES];

  assign in_ready_o  = (upc_q == U_IDLE);
  assign out_valid_o = out_valid_q;
  assign range_sum_o = sum_q;

  assign pos_e  = {{(EW-POS_W){1'b0}}, pos_q};
  assign rend_e = {{(EW-RIGHT_W){1'b0}}, rend_q};
  assign hs_e   = (rend_e > L_E) ? L_E : rend_e;   // saturate right bound
  assign hi_m1  = hi_q - HW'(1);

  assign sum_leaf = rd_q + delta_q;
  assign sum_pair = acc_q + rd_q;

  // Fetch the control word and resolve the branch condition
  always_comb begin
    uw = ucode(upc_q);
    case (uw.cond)
      C_NEVER:     hit = 1'b0;
      C_K_LAST:    hit = (k_q == K_LAST);
      C_NO_REQ:    hit = !in_valid_i;
      C_QUERY:     hit = cmd_q;
      C_POS_OOR:   hit = (pos_e >= L_E);
      C_K_ROOT:    hit = (k_q == NODE_W'(1));
      C_EMPTY:     hit = (pos_e >= hs_e);
      C_LO_EVEN:   hit = !lo_q[0];
      C_HI_EVEN:   hit = !hi_q[0];
      C_WALK_DONE: hit = ((lo_q >> 1) >= (hi_q >> 1));
      C_OUT_BUSY:  hit = out_valid_q && !out_ready_i;
      default:     hit = 1'b0;
    endcase
    en    = !(uw.gate && hit);
    upc_d = hit ? uw.tgt_t : uw.tgt_f;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= U_CLR;
    end else begin
      upc_q <= upc_d;
    end
  end

  // Memory port control
  always_comb begin
    mem_we = en && (uw.mem == M_WR);
    mem_re = en && (uw.mem == M_RD);
    case (uw.addr)
      AD_K:     addr = k_q;
      AD_SIB:   addr = k_q ^ NODE_W'(1);
      AD_PAR:   addr = k_q >> 1;
      AD_LO:    addr = lo_q[NODE_W-1:0];
      AD_HI_M1: addr = hi_m1[NODE_W-1:0];
      default:  addr = k_q;
    endcase
    case (uw.wd)
      WD_ZERO: wdata = '0;
      WD_LEAF: wdata = sum_leaf;
      WD_PAIR: wdata = sum_pair;
      default: wdata = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[addr] <= wdata;
    end
    if (mem_re) begin
      rd_q <= mem_q[addr];
    end
  end

  // Datapath register updates
  always_comb begin
    k_d      = k_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    acc_d    = acc_q;
    pend_d   = en && uw.pend;
    out_load = en && uw.out_load;

    if (en) begin
      case (uw.kop)
        KO_HOLD: k_d = k_q;
        KO_INC:  k_d = k_q + NODE_W'(1);
        KO_LEAF: k_d = NODE_W'(pos_e) + L_N;
        KO_HALF: k_d = k_q >> 1;
        default: k_d = k_q;
      endcase
      case (uw.bnd)
        BO_HOLD: begin
          lo_d = lo_q;
          hi_d = hi_q;
        end
        BO_LOAD: begin
          lo_d = HW'(pos_e) + L_H;
          hi_d = HW'(hs_e) + L_H;
        end
        BO_LO_INC: lo_d = lo_q + HW'(1);
        BO_HI_DEC: hi_d = hi_m1;
        BO_SHIFT: begin
          lo_d = lo_q >> 1;
          hi_d = hi_q >> 1;
        end
        default: begin
          lo_d = lo_q;
          hi_d = hi_q;
        end
      endcase
    end

    // Fold in a node read by the previous step, unless this step owns acc
    case (uw.acc)
      AC_HOLD:  acc_d = pend_q ? sum_pair : acc_q;
      AC_CLEAR: acc_d = '0;
      AC_LEAF:  acc_d = sum_leaf;
      AC_PAIR:  acc_d = sum_pair;
      default:  acc_d = acc_q;
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      k_q         <= k_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    acc_q <= acc_d;
    if (in_valid_i && in_ready_o) begin
      cmd_q   <= command_i;
      pos_q   <= position_i;
      rend_q  <= right_end_i;
      delta_q <= delta_i;
    end
    if (out_load) begin
      sum_q <= acc_q;
    end
  end

endmodule

FILE: design/parst_checker.sv
// Port-level checker for the point-add / range-sum segment tree, with its bind.
// Sees only the top level's ports; no package dependency.
module parst_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic signed [31:0]  range_sum_o
);

  // Hold a stalled result and its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(range_sum_o))
    else $error("stalled result changed or dropped");

  // Drop ready right after a request is taken
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while one is in flight");

  // A new result appears only from a request already in work
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result raised while sequencer was idle");

endmodule

bind point_add_range_sum_tree parst_checker u_parst_checker (.*);

FILE: tb/range_sum_tb_pkg.sv
// Request codes shared by the range-sum tree testbench and its checker.
// No dependencies.
package range_sum_tb_pkg;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_SUM = 1'b1;

endpackage

FILE: tb/range_sum_checker.sv
// Checker for point_add_range_sum_tree: watches both channels, keeps its own copy of the
// leaves, predicts every range sum and compares it with the returned one.
// Depends on parst_pkg and range_sum_tb_pkg.
module range_sum_checker
  import parst_pkg::*;
  import range_sum_tb_pkg::*;
#(
  parameter int unsigned LEAVES = DEF_LEAVES
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic                      command_i,
  input  logic [POS_W-1:0]          position_i,
  input  logic [RIGHT_W-1:0]        right_end_i,
  input  logic signed [DATA_W-1:0]  delta_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic signed [DATA_W-1:0]  range_sum_i,
  output int unsigned               fail_count_o,
  output int unsigned               sums_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [POS_W-1:0]         lo;
    logic [RIGHT_W-1:0]       hi;
    logic signed [DATA_W-1:0] sum;
  } span_sum_t;

  logic signed [DATA_W-1:0] leaf_value [LEAVES];
  span_sum_t                pending_sums [$];
  int unsigned              mismatch_count;

  // Plain sum over the leaves; wraps modulo 2^32 like the tree does.
  function automatic logic signed [DATA_W-1:0] span_sum(int unsigned lo, int unsigned hi);
    logic signed [DATA_W-1:0] acc;
    int unsigned              stop;
    acc  = '0;
    stop = (hi > LEAVES) ? LEAVES : hi;
    for (int unsigned k = lo; k < stop; k++) acc += leaf_value[k];
    return acc;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    span_sum_t head;
    if (!rst_ni) begin
      foreach (leaf_value[k]) leaf_value[k] = '0;
      pending_sums.delete();
      mismatch_count = 0;
      fail_count_o   <= 0;
      sums_pending_o <= 0;
    end else begin
      // Retire before predicting: a sum leaving now never belongs to a request taken now.
      if (out_valid_i && out_ready_i) begin
        if (pending_sums.size() == 0) begin
          $display("%0t: range_sum %0d returned with no query outstanding", $time,
                   range_sum_i);
          mismatch_count++;
        end else begin
          head = pending_sums.pop_front();
          if (range_sum_i !== head.sum) begin
            $display("%0t: range_sum [%0d,%0d) expected %0d actual %0d", $time,
                     head.lo, head.hi, head.sum, range_sum_i);
            mismatch_count++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (command_i == CMD_SUM) begin
          pending_sums.push_back('{position_i, right_end_i, span_sum(position_i, right_end_i)});
        end else if (position_i < LEAVES) begin
          leaf_value[position_i] += delta_i;
        end
      end
      fail_count_o   <= mismatch_count;
      sums_pending_o <= pending_sums.size();
    end
  end

endmodule

FILE: tb/tb_point_add_range_sum_tree.sv
// Testbench top for point_add_range_sum_tree: resets the block, drives directed and random
// add/sum requests with random gaps on both channels, and reports the verdict.
// Depends on parst_pkg, range_sum_tb_pkg and range_sum_checker.
module tb_point_add_range_sum_tree;
  timeunit 1ns;
  timeprecision 1ps;

  import parst_pkg::*;
  import range_sum_tb_pkg::*;

  // Covers clearing all 2*LEAVES nodes, then requests with worst-case gaps and stalls.
  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned RANDOM_REQUESTS = 1130;
  // A query walks the tree level by level; give the tail some slack.
  localparam int unsigned DRAIN_CYCLES    = 80;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic                      command_i;
  logic [POS_W-1:0]          position_i;
  logic [RIGHT_W-1:0]        right_end_i;
  logic signed [DATA_W-1:0]  delta_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic signed [DATA_W-1:0]  range_sum_o;

  int unsigned fail_count;
  int unsigned sums_pending;
  int unsigned cycle_count;
  bit          in_calm;
  bit          out_calm;

  point_add_range_sum_tree #(
    .LEAVES (DEF_LEAVES)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .position_i  (position_i),
    .right_end_i (right_end_i),
    .delta_i     (delta_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .range_sum_o (range_sum_o)
  );

  range_sum_checker #(
    .LEAVES (DEF_LEAVES)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .command_i      (command_i),
    .position_i     (position_i),
    .right_end_i    (right_end_i),
    .delta_i        (delta_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .range_sum_i    (range_sum_o),
    .fail_count_o   (fail_count),
    .sums_pending_o (sums_pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Watchdog: a hung handshake or a sum that never comes ends here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Gap length in cycles: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap(bit calm);
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  // Favor both ends of the leaf row so that adds and narrow queries meet often.
  function automatic int unsigned pick_position();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 20) return $urandom_range(0, 15);
    if (roll < 35) return $urandom_range(DEF_LEAVES - 16, DEF_LEAVES - 1);
    return $urandom_range(0, DEF_LEAVES - 1);
  endfunction

  // Right bound for a query starting at lo: short spans, spans to the end,
  // bounds past the end that must saturate, and empty ranges.
  function automatic int unsigned pick_right(int unsigned lo);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return lo + $urandom_range(1, 32);
    if (roll < 65) return lo + $urandom_range(0, DEF_LEAVES - lo);
    if (roll < 75) return DEF_LEAVES;
    if (roll < 88) return $urandom_range(0, (1 << RIGHT_W) - 1);
    return $urandom_range(0, lo);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_delta();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return $signed($urandom_range(0, 200)) - 100;
    if (roll < 85) return $urandom();
    case ($urandom_range(0, 3))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      default: return 32'h0000_0001;
    endcase
  endfunction

  // Present one request, hold it until taken, then idle for a random gap.
  // Valid stays high into the next request when the gap is zero.
  task automatic send_request(input logic cmd, input logic [POS_W-1:0] pos,
                              input logic [RIGHT_W-1:0] rend,
                              input logic signed [DATA_W-1:0] dlt);
    int unsigned gap;
    in_valid_i  <= 1'b1;
    command_i   <= cmd;
    position_i  <= pos;
    right_end_i <= rend;
    delta_i     <= dlt;
    do @(posedge clk_i); while (!in_ready_o);
    gap = pick_gap(in_calm);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Unused fields carry noise; the block must ignore them.
  task automatic add_at(input int unsigned pos, input logic signed [DATA_W-1:0] dlt);
    send_request(CMD_ADD, POS_W'(pos), RIGHT_W'($urandom_range(0, (1 << RIGHT_W) - 1)),
                 dlt);
  endtask

  task automatic query_span(input int unsigned lo, input int unsigned hi);
    send_request(CMD_SUM, POS_W'(lo), RIGHT_W'(hi), $urandom());
  endtask

  // Result side: random stalls, with calm stretches of steady ready.
  initial begin
    int unsigned stall;
    int unsigned rounds;
    out_ready_i <= 1'b0;
    out_calm = 1'b0;
    rounds   = 0;
    wait (rst_ni);
    forever begin
      if (rounds % 40 == 0) out_calm = ($urandom_range(0, 3) == 0);
      rounds++;
      stall = pick_gap(out_calm);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  initial begin
    int unsigned lo;
    cycle_count  = 0;
    in_calm      = 1'b0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    command_i   <= CMD_ADD;
    position_i  <= '0;
    right_end_i <= '0;
    delta_i     <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: fresh tree reads zero, extremes at both ends, leaf wrap, saturation, empties.
    query_span(0, DEF_LEAVES);
    add_at(0, 32'h7FFF_FFFF);
    add_at(DEF_LEAVES - 1, 32'h8000_0000);
    add_at(DEF_LEAVES / 2, 32'hFFFF_FFFF);
    query_span(0, DEF_LEAVES);
    add_at(0, 32'h0000_0001);
    add_at(DEF_LEAVES - 1, 32'hFFFF_FFFF);
    add_at(1, 32'h0000_0000);
    query_span(0, 1);
    query_span(DEF_LEAVES - 1, DEF_LEAVES);
    query_span(DEF_LEAVES - 1, (1 << RIGHT_W) - 1);
    query_span(0, DEF_LEAVES + 1);
    query_span(0, (1 << RIGHT_W) - 1);
    query_span(DEF_LEAVES / 2, DEF_LEAVES / 2 + 1);
    query_span(1, DEF_LEAVES - 1);
    query_span(3, 7);
    query_span(5, 5);
    query_span(10, 3);
    query_span(0, 0);
    query_span(DEF_LEAVES - 1, 0);
    add_at(DEF_LEAVES / 2 - 1, 32'h1234_5678);
    query_span(DEF_LEAVES / 2 - 1, DEF_LEAVES / 2 + 1);
    query_span(0, DEF_LEAVES);

    // Random: an even mix of adds and queries, gap behavior redrawn every 64 requests.
    for (int unsigned n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 64 == 0) in_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 50) begin
        add_at(pick_position(), pick_delta());
      end else begin
        lo = pick_position();
        query_span(lo, pick_right(lo));
      end
    end
    in_valid_i <= 1'b0;
    // Let the checker count the last request before polling its backlog.
    @(posedge clk_i);

    // Drain: wait for every predicted sum, then give the block time to misbehave.
    while (sums_pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/parst_pkg.sv
design/point_add_range_sum_tree.sv
design/parst_checker.sv
tb/range_sum_tb_pkg.sv
tb/range_sum_checker.sv
tb/tb_point_add_range_sum_tree.sv
